// ----- rtl/scp_pkg.sv -----
package scp_pkg;

    // Image geometry and angle binning
    localparam int AZIMUTH_BINS    = 1440;
    localparam int ELEVATION_ROWS  = 540;
    localparam int BINS_PER_DEGREE = 4;
    localparam int BIN_FACTOR      = 360 * BINS_PER_DEGREE;
    localparam int AZ_OFFSET       = 180 * BINS_PER_DEGREE;
    localparam int EL_OFFSET       = 90 * BINS_PER_DEGREE;
    localparam int BIN_W           = 13;

    // CORDIC arctangent
    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_LATENCY = CORDIC_STEPS + 3;
    localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
    localparam logic [30:0] EIGHTH_TURN  = 31'h2000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    typedef enum logic [1:0] {
        ATAN_CORDIC,
        ATAN_ZERO,
        ATAN_QUARTER,
        ATAN_EIGHTH
    } atan_case_t;

    // Configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [15:0] FLOOR_RESET   = 16'd200;
    localparam logic [15:0] CEILING_RESET = 16'd700;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [15:0]        point_intensity;
        logic [19:0]        point_number;
    } point_t;

    typedef struct packed {
        logic [10:0] column;
        logic [9:0]  row;
        logic [7:0]  pixel_value;
        logic [19:0] map_entry;
        logic        in_range;
    } result_t;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [19:0] number;
    } side_t;

endpackage

// ----- rtl/scp_atan.sv -----
module scp_atan (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] adj,
    input  logic [31:0] opp,
    output logic [30:0] angle
);

    localparam int STEPS = scp_pkg::CORDIC_STEPS;
    localparam int CW    = 44;
    localparam int ZW    = 33;

    scp_pkg::atan_case_t case_in;
    scp_pkg::atan_case_t case_reg [STEPS+2];

    logic [31:0] m0, a16, o16, m16;
    logic [31:0] m1, a4, o4, m4, a2, o2, m2;
    logic [31:0] n1_a_reg, n1_o_reg, n1_a_next, n1_o_next;
    logic [31:0] n2_a_reg, n2_o_reg, n2_a_next, n2_o_next;

    logic signed [CW-1:0] cx_reg [STEPS];
    logic signed [CW-1:0] cy_reg [STEPS];
    logic signed [ZW-1:0] cz_reg [STEPS];

    logic signed [ZW-1:0] z_final;
    logic [30:0] angle_reg, angle_next;

    // Exact answers for an axis or the diagonal
    always_comb
    begin
        priority if (opp == 32'd0)
            case_in = scp_pkg::ATAN_ZERO;
        else if (adj == 32'd0)
            case_in = scp_pkg::ATAN_QUARTER;
        else if (adj == opp)
            case_in = scp_pkg::ATAN_EIGHTH;
        else
            case_in = scp_pkg::ATAN_CORDIC;
    end

    // Normalize: shift both until the larger has its top bit set
    assign m0  = adj | opp;
    assign a16 = (m0[31:16] == 16'd0) ? (adj << 16) : adj;
    assign o16 = (m0[31:16] == 16'd0) ? (opp << 16) : opp;
    assign m16 = a16 | o16;
    assign n1_a_next = (m16[31:24] == 8'd0) ? (a16 << 8) : a16;
    assign n1_o_next = (m16[31:24] == 8'd0) ? (o16 << 8) : o16;

    assign m1 = n1_a_reg | n1_o_reg;
    assign a4 = (m1[31:28] == 4'd0) ? (n1_a_reg << 4) : n1_a_reg;
    assign o4 = (m1[31:28] == 4'd0) ? (n1_o_reg << 4) : n1_o_reg;
    assign m4 = a4 | o4;
    assign a2 = (m4[31:30] == 2'd0) ? (a4 << 2) : a4;
    assign o2 = (m4[31:30] == 2'd0) ? (o4 << 2) : o4;
    assign m2 = a2 | o2;
    assign n2_a_next = m2[31] ? a2 : (a2 << 1);
    assign n2_o_next = m2[31] ? o2 : (o2 << 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_a_reg <= n1_a_next;
            n1_o_reg <= n1_o_next;
            n2_a_reg <= n2_a_next;
            n2_o_reg <= n2_o_next;
            case_reg[0] <= case_in;
            for (int k = 1; k < STEPS + 2; k++)
                case_reg[k] <= case_reg[k-1];
        end
    end

    // One vectoring rotation per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] px, py, dx, dy, x_next, y_next;
        logic signed [ZW-1:0] pz, z_next, step_angle;

        if (i == 0)
        begin : g_first
            assign px = $signed({3'b000, n2_a_reg, 9'd0});
            assign py = $signed({3'b000, n2_o_reg, 9'd0});
            assign pz = '0;
        end
        else
        begin : g_rest
            assign px = cx_reg[i-1];
            assign py = cy_reg[i-1];
            assign pz = cz_reg[i-1];
        end

        assign dx = py >>> i;
        assign dy = px >>> i;
        assign step_angle = $signed({3'b000, scp_pkg::ATAN_TABLE[i]});

        always_comb
        begin
            if (py > 0)
            begin
                x_next = px + dx;
                y_next = py - dy;
                z_next = pz + step_angle;
            end
            else
            begin
                x_next = px - dx;
                y_next = py + dy;
                z_next = pz - step_angle;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i] <= x_next;
                cy_reg[i] <= y_next;
                cz_reg[i] <= z_next;
            end
        end
    end

    // Clamp to the first quadrant, or take the exact answer
    assign z_final = cz_reg[STEPS-1];

    always_comb
    begin
        unique case (case_reg[STEPS+1])
            scp_pkg::ATAN_ZERO:    angle_next = '0;
            scp_pkg::ATAN_QUARTER: angle_next = scp_pkg::QUARTER_TURN;
            scp_pkg::ATAN_EIGHTH:  angle_next = scp_pkg::EIGHTH_TURN;
            default:
            begin
                if (z_final < 0)
                    angle_next = '0;
                else if (z_final > $signed({2'b00, scp_pkg::QUARTER_TURN}))
                    angle_next = scp_pkg::QUARTER_TURN;
                else
                    angle_next = z_final[30:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ----- rtl/spherical_cloud_projection_unit.sv -----
// Projects one laser-scanner point per clock into a 1440 x 540 range image of
// quarter-degree bins: column from the azimuth atan2(y, x), row from the
// elevation atan2(z, sqrt(x^2 + y^2)), pixel byte from the intensity clamped
// between the floor and ceiling registers, map entry from the point number.
// A new point is taken in every cycle that point_stall is low. The pipeline
// holds 70 register stages. Its longest chain is the one-bit-per-stage
// square root (34 stages with the squaring) followed by the 30-step CORDIC
// arctangent (33 stages); the intensity divider and the azimuth arctangent
// run beside it. The pipeline moves as a whole: while a result waits under
// stall, every stage holds and the input stalls as well. Results whose row
// or column falls outside the image carry in_range low. Write the
// configuration registers only while no point is in flight.
module spherical_cloud_projection_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  scp_pkg::point_t                     point,
    output logic                                result_valid,
    input  logic                                result_stall,
    output scp_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [scp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 2;
    localparam int ATAN_LAT   = scp_pkg::ATAN_LATENCY;
    localparam int DIV_STEPS  = 24;
    localparam int SIDE_DLY   = SQRT_LAT + ATAN_LAT;
    localparam int PIX_DLY    = SQRT_LAT + ATAN_LAT - DIV_STEPS - 1;
    localparam int PIPE_LAT   = 1 + SQRT_LAT + ATAN_LAT + 2;
    localparam int BW         = scp_pkg::BIN_W;

    logic en;
    logic vld_reg [PIPE_LAT];

    logic [15:0] floor_reg, ceiling_reg;

    // Input stage
    logic [31:0] ax_next, ay_next, az_next;
    logic [31:0] p_ax_reg, p_ay_reg, p_az_reg;
    logic [15:0] clamp_lo, clamp_v, num_next, div_next;
    logic [15:0] p_num_reg, p_div_reg;
    logic        pix_ok;
    scp_pkg::side_t side_next, p_side_reg;

    // Squares and radial distance
    logic [63:0] sqx_reg, sqy_reg, sum_reg;
    logic [63:0] sq_rad_reg  [SQRT_STEPS-1];
    logic [34:0] sq_rem_reg  [SQRT_STEPS-1];
    logic [31:0] sq_root_reg [SQRT_STEPS];

    // Intensity divider
    logic [23:0] dvd_reg;
    logic [15:0] p_div_reg_d2;
    logic [23:0] dv_dvd_reg [DIV_STEPS-1];
    logic [15:0] dv_d_reg   [DIV_STEPS-1];
    logic [15:0] dv_rem_reg [DIV_STEPS-1];
    logic [7:0]  dv_q_reg   [DIV_STEPS];

    // Alignment delays
    logic [31:0]    az_dly_reg    [SQRT_LAT];
    logic [30:0]    azang_dly_reg [SQRT_LAT];
    scp_pkg::side_t side_dly_reg  [SIDE_DLY];
    logic [7:0]     pix_dly_reg   [PIX_DLY];

    logic [30:0] az_angle, el_angle;

    // Bin stage
    logic [31:0] az_mag, el_mag;
    logic [63:0] az_prod, el_prod;
    logic [BW-1:0] b1_az_bins_reg, b1_el_bins_reg;
    scp_pkg::side_t b1_side_reg;
    logic [7:0]  b1_pix_reg;

    // Output stage
    logic signed [14:0] az_signed, el_signed, col_diff, row_diff;
    logic [14:0] col_abs, row_abs;
    scp_pkg::result_t res_next, res_reg;

    // Hold every stage while a finished result is refused
    assign en           = !(vld_reg[PIPE_LAT-1] && result_stall);
    assign point_stall  = !en;
    assign result_valid = vld_reg[PIPE_LAT-1];
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= point_valid;
            for (int k = 1; k < PIPE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= scp_pkg::FLOOR_RESET;
            ceiling_reg <= scp_pkg::CEILING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                scp_pkg::CFG_FLOOR:   floor_reg   <= cfg_data;
                scp_pkg::CFG_CEILING: ceiling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitudes, signs, clamped intensity
    always_comb
    begin
        ax_next = point.point_x[31] ? (~point.point_x + 32'd1) : point.point_x;
        ay_next = point.point_y[31] ? (~point.point_y + 32'd1) : point.point_y;
        az_next = point.point_z[31] ? (~point.point_z + 32'd1) : point.point_z;

        side_next.neg_x  = point.point_x[31];
        side_next.neg_y  = point.point_y[31];
        side_next.neg_z  = point.point_z[31];
        side_next.number = point.point_number;

        pix_ok   = ceiling_reg > floor_reg;
        clamp_lo = (point.point_intensity < floor_reg) ? floor_reg : point.point_intensity;
        clamp_v  = (clamp_lo > ceiling_reg) ? ceiling_reg : clamp_lo;
        // An empty span yields zero: divide zero by one
        num_next = pix_ok ? (clamp_v - floor_reg) : 16'd0;
        div_next = pix_ok ? (ceiling_reg - floor_reg) : 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ax_reg   <= ax_next;
            p_ay_reg   <= ay_next;
            p_az_reg   <= az_next;
            p_side_reg <= side_next;
            p_num_reg  <= num_next;
            p_div_reg  <= div_next;

            sqx_reg <= 64'(p_ax_reg) * 64'(p_ax_reg);
            sqy_reg <= 64'(p_ay_reg) * 64'(p_ay_reg);
            sum_reg <= sqx_reg + sqy_reg;

            dvd_reg <= {p_num_reg, 8'd0} - {8'd0, p_num_reg};
        end
    end

    // Floor square root, one root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [63:0] rad;
        logic [34:0] rem, rem2, trial;
        logic [31:0] root;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rad  = sum_reg;
            assign rem  = '0;
            assign root = '0;
        end
        else
        begin : g_rest
            assign rad  = sq_rad_reg[k-1];
            assign rem  = sq_rem_reg[k-1];
            assign root = sq_root_reg[k-1];
        end

        assign rem2  = {rem[32:0], rad[63:62]};
        assign trial = {1'b0, root, 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
                sq_root_reg[k] <= {root[30:0], ge};
        end

        if (k < SQRT_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rad_reg[k] <= rad << 2;
                    sq_rem_reg[k] <= ge ? (rem2 - trial) : rem2;
                end
            end
        end
    end

    // Restoring divide for the pixel byte, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [23:0] dvd;
        logic [15:0] d, rem;
        logic [7:0]  q;
        logic [16:0] rem2, diff;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign dvd = dvd_reg;
            assign d   = p_div_reg_d2;
            assign rem = '0;
            assign q   = '0;
        end
        else
        begin : g_rest
            assign dvd = dv_dvd_reg[j-1];
            assign d   = dv_d_reg[j-1];
            assign rem = dv_rem_reg[j-1];
            assign q   = dv_q_reg[j-1];
        end

        assign rem2 = {rem, dvd[23]};
        assign diff = rem2 - {1'b0, d};
        assign ge   = rem2 >= {1'b0, d};

        always_ff @(posedge clk)
        begin
            if (en)
                dv_q_reg[j] <= {q[6:0], ge};
        end

        if (j < DIV_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_dvd_reg[j] <= dvd << 1;
                    dv_d_reg[j]   <= d;
                    dv_rem_reg[j] <= ge ? diff[15:0] : rem2[15:0];
                end
            end
        end
    end

    // Divisor aligned with the scaled numerator
    always_ff @(posedge clk)
    begin
        if (en)
            p_div_reg_d2 <= p_div_reg;
    end

    // Arctangent units: azimuth straight from the magnitudes, elevation after the root
    scp_atan u_az_atan (
        .clk   (clk),
        .en    (en),
        .adj   (p_ax_reg),
        .opp   (p_ay_reg),
        .angle (az_angle)
    );

    scp_atan u_el_atan (
        .clk   (clk),
        .en    (en),
        .adj   (sq_root_reg[SQRT_STEPS-1]),
        .opp   (az_dly_reg[SQRT_LAT-1]),
        .angle (el_angle)
    );

    // Align side data with the elevation angle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_dly_reg[0]    <= p_az_reg;
            azang_dly_reg[0] <= az_angle;
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                az_dly_reg[k]    <= az_dly_reg[k-1];
                azang_dly_reg[k] <= azang_dly_reg[k-1];
            end

            side_dly_reg[0] <= p_side_reg;
            for (int k = 1; k < SIDE_DLY; k++)
                side_dly_reg[k] <= side_dly_reg[k-1];

            pix_dly_reg[0] <= dv_q_reg[DIV_STEPS-1];
            for (int k = 1; k < PIX_DLY; k++)
                pix_dly_reg[k] <= pix_dly_reg[k-1];
        end
    end

    // Quadrant restore and scale to bins, truncating
    always_comb
    begin
        az_mag = side_dly_reg[SIDE_DLY-1].neg_x ?
                 (scp_pkg::HALF_TURN - {1'b0, azang_dly_reg[SQRT_LAT-1]}) :
                 {1'b0, azang_dly_reg[SQRT_LAT-1]};
        el_mag = {1'b0, el_angle};
        az_prod = 64'(az_mag) * 64'(scp_pkg::BIN_FACTOR);
        el_prod = 64'(el_mag) * 64'(scp_pkg::BIN_FACTOR);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_az_bins_reg <= az_prod[32 +: BW];
            b1_el_bins_reg <= el_prod[32 +: BW];
            b1_side_reg    <= side_dly_reg[SIDE_DLY-1];
            b1_pix_reg     <= pix_dly_reg[PIX_DLY-1];
        end
    end

    // Signed bins, offset, fold to column and row
    always_comb
    begin
        az_signed = b1_side_reg.neg_y ? -$signed(15'(b1_az_bins_reg)) :
                                        $signed(15'(b1_az_bins_reg));
        el_signed = b1_side_reg.neg_z ? -$signed(15'(b1_el_bins_reg)) :
                                        $signed(15'(b1_el_bins_reg));
        col_diff  = az_signed - 15'(scp_pkg::AZ_OFFSET);
        row_diff  = el_signed - 15'(scp_pkg::EL_OFFSET);
        col_abs   = col_diff[14] ? 15'(-col_diff) : 15'(col_diff);
        row_abs   = row_diff[14] ? 15'(-row_diff) : 15'(row_diff);

        res_next.column      = col_abs[10:0];
        res_next.row         = row_abs[9:0];
        res_next.pixel_value = b1_pix_reg;
        res_next.map_entry   = b1_side_reg.number;
        res_next.in_range    = (col_abs < 15'(scp_pkg::AZIMUTH_BINS)) &&
                               (row_abs < 15'(scp_pkg::ELEVATION_ROWS));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

endmodule
